// ----- hw/rtl/tlpte_pkg.sv -----
`default_nettype none
package tlpte_pkg;

  localparam int VA_W    = 32;
  localparam int FRAME_W = 20;
  localparam int FLAGS_W = 12;
  localparam int ENTRY_W = FRAME_W + FLAGS_W;
  localparam int REQ_W   = 2;
  localparam int IDX_W   = 10;

  typedef enum logic [REQ_W-1:0] {
    REQ_MAP    = 2'd0,
    REQ_UNMAP  = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_t;

  // Reduces a ten-bit index modulo n by restoring subtraction. With n of at
  // least sixteen the quotient fits in six bits, so six steps suffice.
  function automatic logic [IDX_W-1:0] idx_mod(input logic [IDX_W-1:0] x,
                                               input int unsigned n);
    logic [16:0] r;
    logic [16:0] d;
    r = {7'd0, x};
    for (int k = 5; k >= 0; k--) begin
      d = 17'(n) << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tlpte_ram.sv -----
`default_nettype none
module tlpte_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/two_level_page_table_engine_core.sv -----
// Two-level page table engine.
// Input channel (in_valid/in_ready) carries one request per beat: map, unmap
// or look up virt_addr, with phys_frame and page_flags used by a map. Output
// channel (out_valid/out_ready) returns one result beat per request: hit,
// mapped_frame and status (pool exhausted on a refused map).
// A request is taken in the idle state and reads the directory memory; a
// map, unmap or miss then finishes in S_DIR. A lookup through a valid
// directory entry reads the table memory and finishes in S_TAB. A map that
// allocates a new table clears it one entry a cycle in S_TCLR, writing the
// new entry on the way, and finishes in S_FIN. No new request is taken
// until the engine is back in the idle state.
// After reset the directory is cleared one entry a cycle, while in_ready
// is low; the pool count returns to zero.
// The result sits in an output register, so a new request is taken while it
// waits; if the receiver still stalls when the next result is ready, the
// engine holds that result in its current state until the register frees.
`default_nettype none
module two_level_page_table_engine_core import tlpte_pkg::*; #(
  parameter int DIR_ENTRIES   = 1024,
  parameter int TABLE_ENTRIES = 1024,
  parameter int TABLE_POOL    = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [REQ_W-1:0]   req_type,
  input  wire logic [VA_W-1:0]    virt_addr,
  input  wire logic [FRAME_W-1:0] phys_frame,
  input  wire logic [FLAGS_W-1:0] page_flags,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic               hit,
  output      logic [FRAME_W-1:0] mapped_frame,
  output      logic               status
);

  localparam int DIR_AW = $clog2(DIR_ENTRIES);
  localparam int TAB_IW = $clog2(TABLE_ENTRIES);
  localparam int DENT_W = $clog2(TABLE_POOL + 1);
  localparam int PW     = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
  localparam int SLOTS  = TABLE_POOL * TABLE_ENTRIES;
  localparam int SLOT_W = $clog2(SLOTS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIR, S_TAB, S_TCLR, S_FIN
  } state_t;

  state_t              state, state_next;
  logic [DIR_AW-1:0]   dclr, dclr_next;
  logic [TAB_IW-1:0]   tcnt, tcnt_next;
  logic [DENT_W-1:0]   used, used_next;
  logic [PW-1:0]       tbl_sel, tbl_sel_next;
  req_t                req_q, req_next;
  logic [DIR_AW-1:0]   di_q, di_next;
  logic [TAB_IW-1:0]   ti_q, ti_next;
  logic [ENTRY_W-1:0]  entry_q, entry_next;

  logic                dir_we, dir_re;
  logic [DIR_AW-1:0]   dir_waddr, dir_raddr;
  logic [DENT_W-1:0]   dir_wdata, dir_rdata;
  logic                tab_we, tab_re;
  logic [SLOT_W-1:0]   slot;
  logic [ENTRY_W-1:0]  tab_wdata, tab_rdata;

  logic                accept, can_out, load_out;
  logic                res_hit, res_status;
  logic [FRAME_W-1:0]  res_frame;
  logic [DENT_W-1:0]   dent_dec;
  logic [PW-1:0]       slot_sel;
  logic [TAB_IW-1:0]   slot_idx;
  logic [DIR_AW-1:0]   in_di;
  logic [TAB_IW-1:0]   in_ti;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign can_out  = !out_valid || out_ready;

  assign in_di    = DIR_AW'(idx_mod(virt_addr[31:22], DIR_ENTRIES));
  assign in_ti    = TAB_IW'(idx_mod(virt_addr[21:12], TABLE_ENTRIES));

  assign dent_dec = dir_rdata - DENT_W'(1);
  assign slot_sel = (state == S_TCLR) ? tbl_sel : dent_dec[PW-1:0];
  assign slot_idx = (state == S_TCLR) ? tcnt : ti_q;
  assign slot     = SLOT_W'(SLOT_W'(slot_sel) * SLOT_W'(TABLE_ENTRIES)) + SLOT_W'(slot_idx);

  tlpte_ram #(.DEPTH(DIR_ENTRIES), .WIDTH(DENT_W)) u_dir (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .re    (dir_re),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  tlpte_ram #(.DEPTH(SLOTS), .WIDTH(ENTRY_W)) u_tab (
    .clk   (clk),
    .we    (tab_we),
    .waddr (slot),
    .wdata (tab_wdata),
    .re    (tab_re),
    .raddr (slot),
    .rdata (tab_rdata)
  );

  always_comb begin
    state_next   = state;
    dclr_next    = dclr;
    tcnt_next    = tcnt;
    used_next    = used;
    tbl_sel_next = tbl_sel;
    req_next     = req_q;
    di_next      = di_q;
    ti_next      = ti_q;
    entry_next   = entry_q;
    dir_we       = 1'b0;
    dir_re       = 1'b0;
    dir_waddr    = di_q;
    dir_wdata    = '0;
    dir_raddr    = in_di;
    tab_we       = 1'b0;
    tab_re       = 1'b0;
    tab_wdata    = '0;
    load_out     = 1'b0;
    res_hit      = 1'b0;
    res_frame    = '0;
    res_status   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        dir_we    = 1'b1;
        dir_waddr = dclr;
        dclr_next = dclr + DIR_AW'(1);
        if (dclr == DIR_AW'(DIR_ENTRIES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          dir_re     = 1'b1;
          req_next   = req_t'(req_type);
          di_next    = in_di;
          ti_next    = in_ti;
          entry_next = {phys_frame, page_flags};
          state_next = S_DIR;
        end
      end
      S_DIR: begin
        priority if (req_q == REQ_MAP && dir_rdata == '0) begin
          if (used == DENT_W'(TABLE_POOL)) begin
            if (can_out) begin
              load_out   = 1'b1;
              res_status = 1'b1;
              state_next = S_IDLE;
            end
          end else begin
            dir_we       = 1'b1;
            dir_wdata    = used + DENT_W'(1);
            tbl_sel_next = used[PW-1:0];
            used_next    = used + DENT_W'(1);
            tcnt_next    = '0;
            state_next   = S_TCLR;
          end
        end else if (req_q == REQ_LOOKUP && dir_rdata != '0) begin
          tab_re     = 1'b1;
          state_next = S_TAB;
        end else if (can_out) begin
          // Map or unmap through a live directory entry, or nothing to do.
          load_out = 1'b1;
          if (dir_rdata != '0 && (req_q == REQ_MAP || req_q == REQ_UNMAP)) begin
            tab_we    = 1'b1;
            tab_wdata = (req_q == REQ_MAP) ? entry_q : '0;
          end
          state_next = S_IDLE;
        end else begin
          // The receiver still holds the previous beat, so wait here.
        end
      end
      S_TCLR: begin
        // The new entry is written as the sweep passes its slot.
        tab_we    = 1'b1;
        tab_wdata = (tcnt == ti_q) ? entry_q : '0;
        tcnt_next = tcnt + TAB_IW'(1);
        if (tcnt == TAB_IW'(TABLE_ENTRIES - 1)) begin
          state_next = S_FIN;
        end
      end
      S_TAB: begin
        if (can_out) begin
          load_out   = 1'b1;
          res_hit    = (tab_rdata != '0);
          res_frame  = (tab_rdata != '0) ? tab_rdata[ENTRY_W-1:FLAGS_W] : '0;
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        if (can_out) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      dclr      <= '0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      dclr  <= dclr_next;
      used  <= used_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    tcnt    <= tcnt_next;
    tbl_sel <= tbl_sel_next;
    req_q   <= req_next;
    di_q    <= di_next;
    ti_q    <= ti_next;
    entry_q <= entry_next;
    if (load_out) begin
      hit          <= res_hit;
      mapped_frame <= res_frame;
      status       <= res_status;
    end
  end

  // The pool count moves only on a map that allocates a table.
  a_used_only_on_alloc: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(used) |->
      $past(state == S_DIR && req_q == REQ_MAP && dir_rdata == '0))
    else $error("pool count changed outside an allocation");

  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    used <= DENT_W'(TABLE_POOL))
    else $error("pool count beyond pool size");

  // A result is never loaded over one the receiver has not yet taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !load_out)
    else $error("output register overwritten");

  a_dir_port: assert property (@(posedge clk) disable iff (rst)
    dir_we |-> !dir_re && !tab_re)
    else $error("directory written while a read is issued");

endmodule
`default_nettype wire

// ----- bench/tb_two_level_page_table_engine_core.sv -----
`default_nettype none
import tlpte_pkg::*;

typedef struct packed {
  logic               hit;
  logic [FRAME_W-1:0] frame;
  logic               status;
} walk_result_t;

// Mirror of the page directory and the table pool. Each accepted request
// updates the mirror and queues the result that the engine must return.
class mapping_scoreboard #(
  int DIR_N  = 1024,
  int TAB_N  = 1024,
  int POOL_N = 16
);
  bit [$clog2(POOL_N+1)-1:0] dir_slot [DIR_N];
  bit [ENTRY_W-1:0]          pte_store [POOL_N*TAB_N];
  int unsigned               tables_taken;
  walk_result_t              expected_results [$];
  int unsigned               errors, checked, hits, refusals;
  int unsigned               maps, unmaps, lookups, undefined;

  function void note_request(logic [REQ_W-1:0] req, logic [VA_W-1:0] va,
                             logic [FRAME_W-1:0] frame, logic [FLAGS_W-1:0] flags);
    int unsigned  di, ti, dent, base;
    walk_result_t res;
    di   = va[31:22] % DIR_N;
    ti   = va[21:12] % TAB_N;
    dent = dir_slot[di];
    res  = '0;
    case (req)
      REQ_MAP: begin
        maps++;
        if (dent == 0) begin
          if (tables_taken >= POOL_N) begin
            res.status = 1'b1;
            refusals++;
          end else begin
            // A fresh table is cleared whole before the new entry goes in.
            base = tables_taken * TAB_N;
            for (int k = 0; k < TAB_N; k++) pte_store[base+k] = '0;
            tables_taken++;
            dent = tables_taken;
            dir_slot[di] = dent[$clog2(POOL_N+1)-1:0];
          end
        end
        if (dent != 0) pte_store[(dent-1)*TAB_N+ti] = {frame, flags};
      end
      REQ_UNMAP: begin
        unmaps++;
        if (dent != 0) pte_store[(dent-1)*TAB_N+ti] = '0;
      end
      REQ_LOOKUP: begin
        lookups++;
        // A hit is any nonzero entry; the present bit plays no part.
        if (dent != 0 && pte_store[(dent-1)*TAB_N+ti] != '0) begin
          res.hit   = 1'b1;
          res.frame = pte_store[(dent-1)*TAB_N+ti][ENTRY_W-1:FLAGS_W];
          hits++;
        end
      end
      default: undefined++;
    endcase
    expected_results.push_back(res);
  endfunction

  function void check_result(logic h, logic [FRAME_W-1:0] frame, logic s);
    walk_result_t want;
    if (expected_results.size() == 0) begin
      $error("result beat with no request outstanding");
      errors++;
    end else begin
      want = expected_results.pop_front();
      checked++;
      if (want.hit !== h) begin
        $error("hit: expected %0b, got %0b", want.hit, h);
        errors++;
      end
      if (want.frame !== frame) begin
        $error("mapped_frame: expected %05h, got %05h", want.frame, frame);
        errors++;
      end
      if (want.status !== s) begin
        $error("status: expected %0b, got %0b", want.status, s);
        errors++;
      end
    end
  endfunction
endclass

module tb_two_level_page_table_engine_core;

  localparam int DIR_N          = 1024;
  localparam int TAB_N          = 1024;
  localparam int POOL_N         = 16;
  localparam int RANDOM_ITEMS   = 1150;
  localparam int HOT_DEPTH      = 64;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [REQ_W-1:0]   req_type;
  logic [VA_W-1:0]    virt_addr;
  logic [FRAME_W-1:0] phys_frame;
  logic [FLAGS_W-1:0] page_flags;
  logic               out_valid;
  logic               out_ready;
  logic               hit;
  logic [FRAME_W-1:0] mapped_frame;
  logic               status;

  mapping_scoreboard #(DIR_N, TAB_N, POOL_N) sb;
  logic [VA_W-1:0]  hot_va [$];
  logic [IDX_W-1:0] used_dirs [$];
  bit               tx_calm;
  bit               rx_calm;

  two_level_page_table_engine_core #(
    .DIR_ENTRIES  (DIR_N),
    .TABLE_ENTRIES(TAB_N),
    .TABLE_POOL   (POOL_N)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .virt_addr   (virt_addr),
    .phys_frame  (phys_frame),
    .page_flags  (page_flags),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .mapped_frame(mapped_frame),
    .status      (status)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(hit, mapped_frame, status);
  end

  // Drives one request beat and holds it until the engine takes it. Valid
  // stays high between back-to-back beats so it is never toggled in one step.
  task automatic send_req(logic [REQ_W-1:0] req, logic [VA_W-1:0] va,
                          logic [FRAME_W-1:0] frame, logic [FLAGS_W-1:0] flags);
    int unsigned gap, di;
    bit          was_empty;
    gap = tx_calm ? 0 : $urandom_range(0, 3);
    di  = va[31:22] % DIR_N;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    virt_addr  <= va;
    phys_frame <= frame;
    page_flags <= flags;
    do @(posedge clk); while (!in_ready);
    was_empty = (sb.dir_slot[di] == 0);
    sb.note_request(req, va, frame, flags);
    if (req == REQ_MAP && sb.dir_slot[di] != 0) begin
      if (was_empty) used_dirs.push_back(IDX_W'(di));
      hot_va.push_back(va);
      if (hot_va.size() > HOT_DEPTH) void'(hot_va.pop_front());
    end
  endtask

  task automatic drain_pause();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VA_W-1:0] make_va(logic [IDX_W-1:0] d, logic [IDX_W-1:0] t);
    return {d, t, 12'($urandom_range(0, 4095))};
  endfunction

  function automatic logic [IDX_W-1:0] fresh_dir();
    logic [IDX_W-1:0] d;
    do d = IDX_W'($urandom_range(0, DIR_N-1)); while (sb.dir_slot[d] != 0);
    return d;
  endfunction

  function automatic logic [VA_W-1:0] pick_va(int unsigned hot_pct, int unsigned dir_pct);
    int unsigned r;
    logic [IDX_W-1:0] t;
    r = $urandom_range(0, 99);
    t = IDX_W'($urandom_range(0, TAB_N-1));
    if (r < hot_pct && hot_va.size() != 0) begin
      return {hot_va[$urandom_range(0, hot_va.size()-1)][VA_W-1:12],
              12'($urandom_range(0, 4095))};
    end else if (r < hot_pct + dir_pct && used_dirs.size() != 0) begin
      return make_va(used_dirs[$urandom_range(0, used_dirs.size()-1)], t);
    end
    return $urandom();
  endfunction

  task automatic run_random(int unsigned count);
    int unsigned      r, done;
    logic [REQ_W-1:0] req;
    logic [VA_W-1:0]  va;
    logic [FRAME_W-1:0] frame;
    logic [FLAGS_W-1:0] flags;
    done = 0;
    while (done < count) begin
      if (done % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      if (done == count / 3 || done == (2 * count) / 3) drain_pause();
      r     = $urandom_range(0, 99);
      frame = ($urandom_range(0, 9) == 0) ? '0 : FRAME_W'($urandom());
      flags = ($urandom_range(0, 9) == 0) ? '0 : FLAGS_W'($urandom());
      if (r < 35) begin
        req = REQ_MAP;
        // Now and then a map lands on an empty directory entry and takes
        // a table from the pool; most maps fill tables already in use.
        if ($urandom_range(0, 99) < 4) va = make_va(fresh_dir(), IDX_W'($urandom()));
        else va = pick_va(40, 55);
      end else if (r < 50) begin
        req = REQ_UNMAP;
        va  = pick_va(70, 20);
      end else if (r < 95) begin
        req = REQ_LOOKUP;
        va  = pick_va(70, 20);
      end else begin
        req = REQ_UNDEF;
        va  = $urandom();
      end
      send_req(req, va, frame, flags);
      if (req != REQ_UNDEF) done++;
    end
  endtask

  initial begin : stimulus
    logic [VA_W-1:0] va;
    sb         = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    req_type   = REQ_MAP;
    virt_addr  = '0;
    phys_frame = '0;
    page_flags = '0;
    tx_calm    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty directory, unknown request, then the extremes of every field.
    send_req(REQ_LOOKUP, 32'h0000_0000, '0, '0);
    send_req(REQ_UNMAP, 32'hFFFF_FFFF, '1, '1);
    send_req(REQ_UNDEF, 32'hFFFF_FFFF, '1, '1);
    send_req(REQ_MAP, 32'hFFFF_FFFF, '1, '1);
    send_req(REQ_LOOKUP, 32'hFFFF_FFFF, '0, '0);
    send_req(REQ_LOOKUP, 32'hFFC0_0FFF, '0, '0);
    // A zero entry reads back as a miss.
    send_req(REQ_MAP, 32'hFFC0_0000, '0, '0);
    send_req(REQ_LOOKUP, 32'hFFC0_0000, '1, '1);
    send_req(REQ_MAP, 32'h0000_0000, '0, 12'h001);
    send_req(REQ_LOOKUP, 32'h0000_0ABC, '0, '0);
    send_req(REQ_MAP, 32'h0000_0000, 20'hA5A5A, 12'h5A5);
    send_req(REQ_LOOKUP, 32'h0000_0000, '0, '0);
    send_req(REQ_UNMAP, 32'h0000_0FFF, '0, '0);
    send_req(REQ_LOOKUP, 32'h0000_0000, '0, '0);
    send_req(REQ_UNMAP, 32'hFFFF_F000, '0, '0);
    send_req(REQ_LOOKUP, 32'hFFFF_FFFF, '0, '0);
    va = {10'h155, 10'h2AA, 12'h5A5};
    send_req(REQ_MAP, va, 20'h5A5A5, 12'hA5A);
    send_req(REQ_UNDEF, va, '0, '0);
    send_req(REQ_LOOKUP, va, '0, '0);
    send_req(REQ_LOOKUP, {10'h2AA, 10'h155, 12'hA5A}, '0, '0);
    drain_pause();

    run_random(RANDOM_ITEMS);

    // Use up whatever is left of the pool, then show that maps are refused
    // and that a refused map leaves its address unmapped.
    while (sb.refusals < 3) begin
      va = make_va(fresh_dir(), IDX_W'($urandom()));
      send_req(REQ_MAP, va, FRAME_W'($urandom()), FLAGS_W'($urandom()));
      send_req(REQ_LOOKUP, va, '0, '0);
    end
    send_req(REQ_UNMAP, va, '0, '0);
    send_req(REQ_MAP, hot_va[hot_va.size()-1], '1, '0);
    send_req(REQ_LOOKUP, hot_va[hot_va.size()-1], '0, '0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d maps, %0d unmaps, %0d lookups and %0d undefined requests;",
             sb.maps, sb.unmaps, sb.lookups, sb.undefined);
    $display("%0d results checked, %0d lookup hits, %0d tables allocated, %0d maps refused.",
             sb.checked, sb.hits, sb.tables_taken, sb.refusals);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("tb_two_level_page_table_engine_core passed");
    end else begin
      $display("tb_two_level_page_table_engine_core failed");
    end
    $finish;
  end

  // Result side: a random number of stalled cycles before each beat, with
  // occasional stretches where ready stays high throughout.
  initial begin : receiver
    int unsigned stall, beats;
    out_ready = 1'b0;
    rx_calm   = 1'b0;
    beats     = 0;
    @(negedge clk);
    forever begin
      if (beats % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      stall = rx_calm ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready && !rst));
      beats++;
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $error("no beat on either channel for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_two_level_page_table_engine_core failed");
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
hw/rtl/tlpte_pkg.sv
hw/rtl/tlpte_ram.sv
hw/rtl/two_level_page_table_engine_core.sv
bench/tb_two_level_page_table_engine_core.sv
